### hdl/mstb_pkg.sv
// shared constants, codes and types for the timer bank
package mstb_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int DUR_W  = 24;
  localparam int ID_W   = 16;
  localparam int KIND_W = 2;

  localparam logic [DUR_W-1:0] ELAPSED_MAX = {DUR_W{1'b1}};

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [KIND_W-1:0] EV_ADD_OK   = 2'd0;
  localparam logic [KIND_W-1:0] EV_ADD_FULL = 2'd1;
  localparam logic [KIND_W-1:0] EV_FIRE     = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [DUR_W-1:0] duration;
    logic [DUR_W-1:0] elapsed;
    logic             periodic;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch the incoming item, clear scan indexes
    logic add;    // perform the add and emit its result
    logic rd;     // read the slot memory
    logic step;   // retire the slot under evaluation
    logic flush;  // end of tick: commit count, emit held fire
  } mstb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic empty;
    logic fire;
    logic last_entry;
    logic held_valid;
    logic out_free;
  } mstb_stat_t;

endpackage

### hdl/mstb_if.sv
// handshake channels for input items and result items
interface mstb_in_if import mstb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [DUR_W-1:0] duration_ticks;
  logic             periodic;

  modport source (output valid, output func, output duration_ticks, output periodic,
                  input ready);
  modport sink (input valid, input func, input duration_ticks, input periodic,
                output ready);
endinterface

interface mstb_out_if import mstb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [ID_W-1:0]   timer_id;
  logic              last_result;

  modport source (output valid, output event_kind, output timer_id, output last_result,
                  input ready);
  modport sink (input valid, input event_kind, input timer_id, input last_result,
                output ready);
endinterface

### hdl/mstb_datapath.sv
// slot memory, scan indexes, held fire and output register of the timer bank
module mstb_datapath import mstb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  mstb_cmd_t        cmd,
  output mstb_stat_t       stat,
  input  logic             in_func,
  input  logic [DUR_W-1:0] in_duration,
  input  logic             in_periodic,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [ID_W-1:0]  out_id,
  output logic             out_last
);

  slot_t mem [SLOTS];
  slot_t rd_data;

  logic             item_func;
  logic [DUR_W-1:0] item_duration;
  logic             item_periodic;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] wr_idx;
  logic [ID_W-1:0]  next_id;
  logic [ID_W-1:0]  held_id;
  logic             held_valid;

  logic [CNT_W-1:0] rd_idx_inc;
  logic [DUR_W-1:0] elapsed_inc;
  logic             fire;
  logic             keep;
  logic             full;
  logic [ID_W-1:0]  new_id;
  logic             wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_t            wr_data;
  logic [SLOT_W-1:0] rd_addr;
  logic             emit;
  logic [KIND_W-1:0] emit_kind;
  logic [ID_W-1:0]  emit_id;
  logic             emit_last;

  assign rd_idx_inc  = rd_idx + CNT_W'(1);
  assign elapsed_inc = (rd_data.elapsed == ELAPSED_MAX) ? rd_data.elapsed
                                                        : rd_data.elapsed + DUR_W'(1);
  assign fire        = elapsed_inc >= rd_data.duration;
  assign keep        = !fire || rd_data.periodic;
  assign full        = count == CNT_W'(SLOTS);
  assign new_id      = (next_id == {ID_W{1'b1}}) ? ID_W'(1) : next_id + ID_W'(1);

  assign stat.is_tick    = item_func == FUNC_TICK;
  assign stat.empty      = count == '0;
  assign stat.fire       = fire;
  assign stat.last_entry = rd_idx_inc == count;
  assign stat.held_valid = held_valid;
  assign stat.out_free   = !out_valid || out_ready;

  // one write port: add appends at count, a scan step compacts at wr_idx
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_idx[SLOT_W-1:0];
    wr_data = '{id: rd_data.id, duration: rd_data.duration,
                elapsed: fire ? '0 : elapsed_inc, periodic: rd_data.periodic};
    if (cmd.add && !full) begin
      wr_en   = 1'b1;
      wr_addr = count[SLOT_W-1:0];
      wr_data = '{id: new_id, duration: item_duration,
                  elapsed: item_periodic ? ELAPSED_MAX : '0, periodic: item_periodic};
    end else if (cmd.step && keep) begin
      wr_en = 1'b1;
    end
  end

  assign rd_addr = cmd.step ? rd_idx_inc[SLOT_W-1:0] : rd_idx[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  // result selection
  always_comb begin
    emit      = 1'b0;
    emit_kind = EV_FIRE;
    emit_id   = held_id;
    emit_last = 1'b0;
    if (cmd.add) begin
      emit      = 1'b1;
      emit_kind = full ? EV_ADD_FULL : EV_ADD_OK;
      emit_id   = full ? '0 : new_id;
      emit_last = 1'b1;
    end else if (cmd.step && fire && held_valid) begin
      emit = 1'b1;
    end else if (cmd.flush && held_valid) begin
      emit      = 1'b1;
      emit_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_func     <= in_func;
      item_duration <= in_duration;
      item_periodic <= in_periodic;
    end
    if (cmd.step && fire) begin
      held_id <= rd_data.id;
    end
    if (emit) begin
      out_kind <= emit_kind;
      out_id   <= emit_id;
      out_last <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      next_id    <= '0;
      rd_idx     <= '0;
      wr_idx     <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_idx     <= '0;
        wr_idx     <= '0;
        held_valid <= 1'b0;
      end
      if (cmd.add && !full) begin
        count   <= count + CNT_W'(1);
        next_id <= new_id;
      end
      if (cmd.step) begin
        rd_idx <= rd_idx_inc;
        if (keep) begin
          wr_idx <= wr_idx + CNT_W'(1);
        end
        if (fire) begin
          held_valid <= 1'b1;
        end
      end
      if (cmd.flush) begin
        count      <= wr_idx;
        held_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/mstb_ctrl.sv
// sequencing state machine of the timer bank
module mstb_ctrl import mstb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  mstb_stat_t stat,
  output mstb_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_ADD    = 6'b000100,
    S_READ   = 6'b001000,
    S_EVAL   = 6'b010000,
    S_FLUSH  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   advance;

  assign in_ready = state == S_IDLE;
  // a new fire can only be held once the previous one has left
  assign advance  = !(stat.fire && stat.held_valid && !stat.out_free);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.is_tick) begin
          state_next = S_ADD;
        end else if (stat.empty) begin
          state_next = S_FLUSH;
        end else begin
          state_next = S_READ;
        end
      end
      S_ADD: begin
        if (stat.out_free) begin
          cmd.add    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (advance) begin
          cmd.step = 1'b1;
          cmd.rd   = !stat.last_entry;
          if (stat.last_entry) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!stat.held_valid || stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/multi_slot_timer_bank_unit.sv
// top level of the multi-slot timer bank
//
//  channel  dir  beat contents
//  -------  ---  ------------------------------------------------
//  item     in   func, duration_ticks, periodic
//  result   out  event_kind, timer_id, last_result
//
// an add goes through accept, decode and write, the write waiting on a free
// output register; a tick scans the occupied slots one slot per cycle when not
// stalled, through the 1R1W slot memory (read, evaluate, compact write-back)
// a fire is held one step so the final fire of a tick can carry last_result;
// the held fire leaves through the output register, and the scan stalls only
// when a second fire is found while that register is still full
// synchronous reset clears the slot count, the id counter and all control;
// the slot memory itself is not cleared, only occupied entries are ever read
module multi_slot_timer_bank_unit import mstb_pkg::*; (
  input logic       clk,
  input logic       rst,
  mstb_in_if.sink   item,
  mstb_out_if.source result
);

  mstb_cmd_t  cmd;
  mstb_stat_t stat;

  // controller: accepts an item only when idle, then sequences add or scan
  mstb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: slot memory, indexes, held fire, registered result beat
  mstb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_func     (item.func),
    .in_duration (item.duration_ticks),
    .in_periodic (item.periodic),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_kind    (result.event_kind),
    .out_id      (result.timer_id),
    .out_last    (result.last_result)
  );

endmodule
